/* sv/obhb_pkg.sv */
package obhb_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int ADDR_W    = $clog2(MAX_DEPTH);
  localparam int LEN_W     = ADDR_W + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_DEPTH);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

  typedef struct packed {
    logic       op;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic issue;
    logic last;
  } rd_issue_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

/* sv/obhb_mem.sv */
module obhb_mem (
  input  logic             clk,
  input  obhb_pkg::mem_req_t req,
  output logic [7:0]       rdata
);
  import obhb_pkg::*;

  logic [7:0] store [MAX_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      store[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= store[req.raddr];
    end
  end

endmodule

/* sv/obhb_ctrl.sv */
module obhb_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  obhb_pkg::in_item_t        item,
  input  logic                      clear,
  input  logic [obhb_pkg::LEN_W-1:0] length,
  output logic                      busy,
  output obhb_pkg::mem_req_t        mem_req,
  output obhb_pkg::rd_issue_t       rd_issue
);
  import obhb_pkg::*;

  state_t            state, state_next;
  logic [ADDR_W-1:0] wr_pos, wr_pos_next;
  logic              wrapped, wrapped_next;
  logic [ADDR_W-1:0] slot, slot_next;
  logic [LEN_W-1:0]  remaining, remaining_next;

  // Shared pointer advance: one increment and one compare against the length,
  // used for the write position when idle and for the read slot otherwise.
  logic [ADDR_W-1:0] adv_in;
  logic [LEN_W-1:0]  adv_sum;
  logic              adv_wrap;
  logic [ADDR_W-1:0] adv_out;

  assign adv_in   = (state == ST_READ) ? slot : wr_pos;
  assign adv_sum  = {1'b0, adv_in} + LEN_W'(1);
  assign adv_wrap = (adv_sum >= length);
  assign adv_out  = adv_wrap ? '0 : adv_sum[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_pos    <= '0;
      wrapped   <= 1'b0;
      slot      <= '0;
      remaining <= '0;
    end else begin
      state     <= state_next;
      wr_pos    <= wr_pos_next;
      wrapped   <= wrapped_next;
      slot      <= slot_next;
      remaining <= remaining_next;
    end
  end

  always_comb begin
    state_next     = state;
    wr_pos_next    = wr_pos;
    wrapped_next   = wrapped;
    slot_next      = slot;
    remaining_next = remaining;
    mem_req.we     = 1'b0;
    mem_req.waddr  = wr_pos;
    mem_req.wdata  = item.data_in;
    mem_req.re     = 1'b0;
    mem_req.raddr  = slot;
    rd_issue.issue = 1'b0;
    rd_issue.last  = 1'b0;
    busy           = (state != ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (clear) begin
          wr_pos_next  = '0;
          wrapped_next = 1'b0;
        end else if (accept && item.op == OP_WRITE) begin
          mem_req.we  = 1'b1;
          wr_pos_next = adv_out;
          if (adv_wrap) begin
            wrapped_next = 1'b1;
          end
        end else if (accept && item.op == OP_READ) begin
          // An empty buffer gives nothing and the block stays idle.
          if (wrapped) begin
            slot_next      = wr_pos;
            remaining_next = length;
            state_next     = ST_READ;
          end else if (wr_pos != '0) begin
            slot_next      = '0;
            remaining_next = {1'b0, wr_pos};
            state_next     = ST_READ;
          end
        end
      end
      ST_READ: begin
        mem_req.re     = 1'b1;
        rd_issue.issue = 1'b1;
        rd_issue.last  = (remaining == LEN_W'(1));
        slot_next      = adv_out;
        remaining_next = remaining - LEN_W'(1);
        if (remaining == LEN_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/overwriting_byte_history_buffer.sv */
// Overwriting byte history buffer: keeps the most recent bytes of a stream.
//
// Command channel: a transaction is taken at a rising edge where start is
// high and busy is low. cmd.op selects a write (store cmd.data_in) or a read
// (send out the retained bytes, oldest first).
// A write completes in its own cycle and busy stays low, so writes can be
// taken one per cycle. Once the store holds as many bytes as the length, each new
// byte replaces the oldest one.
// A read raises busy while the retained bytes (up to the length) are sent
// out. Results follow, one per cycle, on result with strobe high for exactly
// one cycle each; the first appears after the controller enters its read
// state and the store's registered read data and the strobe register are
// loaded. result.last marks the newest byte. A read of an empty buffer gives
// no result and leaves busy low. The pace of a readout is set by the single
// read port of the byte store, one address per cycle.
// The receiver cannot stall: every strobe cycle is a delivered transaction.
// Configuration: cfg_valid/cfg_ready write the length (clamped to 2..64) and
// empty the buffer. cfg_ready is low while busy or while start is high, so a
// length write never lands in the same cycle as a command.
// Reset (rst, synchronous) empties the buffer and sets the length to 64.
module overwriting_byte_history_buffer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  obhb_pkg::in_item_t         cmd,
  output logic                       strobe,
  output obhb_pkg::out_item_t        result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [obhb_pkg::LEN_W-1:0] cfg_data
);
  import obhb_pkg::*;

  logic             accept;
  logic             cfg_write;
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] length_next;
  mem_req_t         mem_req;
  rd_issue_t        rd_issue;
  logic [7:0]       rdata;
  logic             last_q;

  assign accept    = start && !busy;
  assign cfg_ready = !busy && !start;
  assign cfg_write = cfg_valid && cfg_ready;

  // Lengths outside the supported range are pinned to its nearest end.
  always_comb begin
    priority if (cfg_data < LEN_MIN) begin
      length_next = LEN_MIN;
    end else if (cfg_data > LEN_MAX) begin
      length_next = LEN_MAX;
    end else begin
      length_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= LEN_RESET;
    end else if (cfg_write) begin
      length <= length_next;
    end
  end

  obhb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (cmd),
    .clear    (cfg_write),
    .length   (length),
    .busy     (busy),
    .mem_req  (mem_req),
    .rd_issue (rd_issue)
  );

  obhb_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // The store's read data is registered, so the strobe and last flag are
  // registered as well to line up with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      last_q <= 1'b0;
    end else begin
      strobe <= rd_issue.issue;
      last_q <= rd_issue.last;
    end
  end

  assign result.data_out = rdata;
  assign result.last     = last_q;

endmodule

/* sv/obhb_checker.sv */
module obhb_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input obhb_pkg::in_item_t  cmd,
  input logic                strobe,
  input obhb_pkg::out_item_t result,
  input logic                cfg_valid,
  input logic                cfg_ready
);
  import obhb_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("block not quiet after reset");

  a_strobe_follows_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result without a readout in progress");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("result right after the newest byte");

  a_write_single_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.op == OP_WRITE |=> !busy && !strobe)
    else $error("write transaction did not complete in one cycle");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !busy)
    else $error("configuration taken while busy");

endmodule

bind overwriting_byte_history_buffer obhb_checker u_obhb_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .cmd       (cmd),
  .strobe    (strobe),
  .result    (result),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
